>>> hdl/usrc_pkg.sv
package usrc_pkg;

    // Counter width and the fixed width of the reported totals.
    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int TOTAL_BITS         = 16;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 16'hFFFF;

    // Configuration port.
    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;
    localparam logic REG_CJK_THRESHOLD = 1'b0;  // register index, taken from paddr[2]
    localparam logic [8:0] THRESHOLD_RESET = 9'd128;

    // Code point ranges used for classing.
    localparam logic [20:0] CJK_A_LO   = 21'h003400;
    localparam logic [20:0] CJK_A_HI   = 21'h009FFF;
    localparam logic [20:0] CJK_B_LO   = 21'h00F900;
    localparam logic [20:0] CJK_B_HI   = 21'h00FAFF;
    localparam logic [20:0] CJK_C_LO   = 21'h020000;
    localparam logic [20:0] CJK_C_HI   = 21'h02FA1F;
    localparam logic [20:0] UPPER_LO   = 21'h000041;
    localparam logic [20:0] UPPER_HI   = 21'h00005A;
    localparam logic [20:0] LOWER_LO   = 21'h000061;
    localparam logic [20:0] LOWER_HI   = 21'h00007A;
    localparam logic [20:0] LETTER_LO  = 21'h0000C0;
    localparam logic [20:0] LETTER_HI  = 21'h002FFF;

    // One input beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_text;
    } in_t;

    // One result beat.
    typedef struct packed {
        logic                  cjk_majority;
        logic [TOTAL_BITS-1:0] letter_total;
        logic [TOTAL_BITS-1:0] cjk_total;
    } out_t;

    // Open UTF-8 sequence.
    typedef struct packed {
        logic [1:0]  bytes_expected;
        logic [20:0] partial;
    } dec_state_t;

    // Class of a code point completed by the current byte.
    typedef struct packed {
        logic letter;
        logic cjk;
    } cls_t;

endpackage

>>> hdl/usrc_decode.sv
module usrc_decode (
    input  usrc_pkg::dec_state_t cur,
    input  logic [7:0]           data_byte,
    input  logic                 has_byte,
    output usrc_pkg::dec_state_t nxt,
    output usrc_pkg::cls_t       cls
);
    import usrc_pkg::*;

    logic [20:0] cp;
    logic [20:0] shifted;
    logic        cp_done;
    logic        as_lead;
    logic        is_cjk;
    logic        is_alpha;

    assign shifted = {cur.partial[14:0], data_byte[5:0]};

    always_comb
    begin
        nxt     = cur;
        cp      = '0;
        cp_done = 1'b0;
        as_lead = 1'b0;
        if (has_byte)
        begin
            if (cur.bytes_expected != 2'd0)
            begin
                if (data_byte[7:6] == 2'b10)
                begin
                    nxt.bytes_expected = cur.bytes_expected - 2'd1;
                    if (cur.bytes_expected == 2'd1)
                    begin
                        cp          = shifted;
                        cp_done     = 1'b1;
                        nxt.partial = '0;
                    end
                    else
                    begin
                        nxt.partial = shifted;
                    end
                end
                else
                begin
                    // Broken sequence: drop it and take this byte as a lead.
                    nxt     = '0;
                    as_lead = 1'b1;
                end
            end
            else
            begin
                as_lead = 1'b1;
            end
        end

        if (as_lead)
        begin
            if (data_byte[7] == 1'b0)
            begin
                cp      = {13'd0, data_byte};
                cp_done = 1'b1;
            end
            else if (data_byte[7:5] == 3'b110)
            begin
                nxt.bytes_expected = 2'd1;
                nxt.partial        = {16'd0, data_byte[4:0]};
            end
            else if (data_byte[7:4] == 4'b1110)
            begin
                nxt.bytes_expected = 2'd2;
                nxt.partial        = {17'd0, data_byte[3:0]};
            end
            else if (data_byte[7:3] == 5'b11110)
            begin
                nxt.bytes_expected = 2'd3;
                nxt.partial        = {18'd0, data_byte[2:0]};
            end
            // Any other lead byte is ignored.
        end
    end

    assign is_cjk   = cp inside {[CJK_A_LO:CJK_A_HI], [CJK_B_LO:CJK_B_HI], [CJK_C_LO:CJK_C_HI]};
    assign is_alpha = cp inside {[UPPER_LO:UPPER_HI], [LOWER_LO:LOWER_HI],
                                 [LETTER_LO:LETTER_HI]};

    assign cls.cjk    = cp_done && is_cjk;
    assign cls.letter = cp_done && (is_cjk || is_alpha);

endmodule

>>> hdl/usrc_ratio.sv
module usrc_ratio #(
    parameter int COUNT_BITS = usrc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [8:0]            threshold,
    input  logic                  snap_valid,
    input  logic [COUNT_BITS-1:0] letters,
    input  logic [COUNT_BITS-1:0] cjk,
    output logic                  ready,
    output logic                  out_valid,
    input  logic                  out_stall,
    output usrc_pkg::out_t        out_data
);
    import usrc_pkg::*;

    localparam int PW = COUNT_BITS + 9;
    localparam int WW = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;

    logic [PW-1:0]   prod;
    logic [PW-1:0]   scaled;
    logic [WW-1:0]   letters_w;
    logic [WW-1:0]   cjk_w;
    logic            hit;
    out_t            result;
    logic            out_valid_reg;
    logic            out_valid_next;
    out_t            out_data_reg;
    logic            load;

    assign prod   = PW'(threshold) * PW'(letters);
    assign scaled = {1'b0, cjk, 8'd0};
    assign hit    = (letters != '0) && (scaled >= prod);

    assign letters_w = WW'(letters);
    assign cjk_w     = WW'(cjk);

    always_comb
    begin
        result.cjk_majority = hit;
        result.letter_total = (letters_w > WW'(TOTAL_MAX)) ? TOTAL_MAX
                                                           : letters_w[TOTAL_BITS-1:0];
        result.cjk_total    = (cjk_w > WW'(TOTAL_MAX)) ? TOTAL_MAX
                                                       : cjk_w[TOTAL_BITS-1:0];
    end

    assign ready = !out_valid_reg || !out_stall;
    assign load  = snap_valid && ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ready)
        begin
            out_valid_next = snap_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hdl/utf8_script_ratio_classifier.sv
// UTF-8 script-ratio classifier. Bytes of a text arrive one per beat on the
// input channel and are decoded as UTF-8 (lead bytes 00-7F, C0-DF, E0-EF and
// F0-F7, no overlong or surrogate checks); each code point in a letter or CJK
// range is counted as a letter and, if CJK, as CJK as well. The beat that
// carries end_of_text yields one result beat: the two totals, clipped to 16
// bits, and cjk_majority, set when cjk*256 >= cjk_threshold_q8*letters with a
// nonzero letter count. All text state then clears; the threshold register at
// APB address 0 keeps its value (reset 128). The block takes one byte every
// cycle while in_stall is low, with no gaps between texts. The decode and the
// saturating counter update finish in the cycle a byte is accepted; the end
// beat's count pair passes through a staging register and then the output
// register, in front of which sit the threshold multiply and compare. One
// finished count pair can wait in the staging register while a result is
// stalled, so input stalls only when both registers are full and the output is held.
module utf8_script_ratio_classifier #(
    parameter int COUNT_BITS = usrc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Byte input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  usrc_pkg::in_t                  in_data,
    // Result output
    output logic                           out_valid,
    input  logic                           out_stall,
    output usrc_pkg::out_t                 out_data,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [usrc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [usrc_pkg::DATA_BITS-1:0] pwdata,
    output logic [usrc_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready
);
    import usrc_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Decoder state and counters for the text in progress.
    dec_state_t            state_reg;
    dec_state_t            state_next;
    dec_state_t            dec_nxt;
    cls_t                  cls;
    logic [COUNT_BITS-1:0] letter_reg;
    logic [COUNT_BITS-1:0] letter_next;
    logic [COUNT_BITS-1:0] letter_bumped;
    logic [COUNT_BITS-1:0] cjk_reg;
    logic [COUNT_BITS-1:0] cjk_next;
    logic [COUNT_BITS-1:0] cjk_bumped;

    // Staging register for finished counts.
    logic                  snap_valid_reg;
    logic                  snap_valid_next;
    logic [COUNT_BITS-1:0] snap_letter_reg;
    logic [COUNT_BITS-1:0] snap_cjk_reg;
    logic                  ratio_ready;

    logic                  accept;
    logic                  end_accept;
    logic [8:0]            threshold_reg;
    logic                  cfg_write;

    // The current byte is decoded against the open sequence.
    usrc_decode u_decode (
        .cur       (state_reg),
        .data_byte (in_data.data_byte),
        .has_byte  (in_data.has_byte),
        .nxt       (dec_nxt),
        .cls       (cls)
    );

    assign accept     = in_valid && !in_stall;
    assign end_accept = accept && in_data.end_of_text;

    // Input waits only while a count pair is staged and the output stage is held.
    assign in_stall = snap_valid_reg && !ratio_ready;

    // Counters saturate at all ones.
    assign letter_bumped = (cls.letter && letter_reg != CNT_MAX) ? letter_reg + 1'b1 : letter_reg;
    assign cjk_bumped    = (cls.cjk && cjk_reg != CNT_MAX) ? cjk_reg + 1'b1 : cjk_reg;

    always_comb
    begin
        state_next      = state_reg;
        letter_next     = letter_reg;
        cjk_next        = cjk_reg;
        snap_valid_next = snap_valid_reg && !ratio_ready;
        if (accept)
        begin
            if (in_data.end_of_text)
            begin
                // The byte on the end beat counts first, then the text clears;
                // any sequence still open is dropped.
                state_next      = '0;
                letter_next     = '0;
                cjk_next        = '0;
                snap_valid_next = 1'b1;
            end
            else
            begin
                state_next  = dec_nxt;
                letter_next = letter_bumped;
                cjk_next    = cjk_bumped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '0;
            letter_reg     <= '0;
            cjk_reg        <= '0;
            snap_valid_reg <= 1'b0;
            threshold_reg  <= THRESHOLD_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            letter_reg     <= letter_next;
            cjk_reg        <= cjk_next;
            snap_valid_reg <= snap_valid_next;
            if (cfg_write)
            begin
                threshold_reg <= pwdata[8:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_accept)
        begin
            snap_letter_reg <= letter_bumped;
            snap_cjk_reg    <= cjk_bumped;
        end
    end

    // Threshold compare and the result register.
    usrc_ratio #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ratio (
        .clk        (clk),
        .rst_n      (rst_n),
        .threshold  (threshold_reg),
        .snap_valid (snap_valid_reg),
        .letters    (snap_letter_reg),
        .cjk        (snap_cjk_reg),
        .ready      (ratio_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    // APB port: one register, always ready. Writes to other addresses are dropped.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CJK_THRESHOLD);
    assign prdata    = (paddr[2] == REG_CJK_THRESHOLD) ? DATA_BITS'(threshold_reg) : '0;

    // Every CJK code point is also a letter, so the CJK count never leads.
    assert property (@(posedge clk) disable iff (!rst_n) cjk_reg <= letter_reg)
        else $error("CJK count exceeds letter count");

    // Partial code point bits exist only while a sequence is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.bytes_expected == 2'd0) |-> (state_reg.partial == '0))
        else $error("partial code point left with no open sequence");

    // An accepted end beat leaves the text state cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        end_accept |=> (letter_reg == '0 && cjk_reg == '0 && state_reg == '0))
        else $error("text state not cleared after end beat");

    // Input is held only when a staged count pair cannot move on.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (snap_valid_reg && out_valid && out_stall))
        else $error("input stalled without a blocked result");

endmodule
